FILE: hdl/plq_pkg.sv
// plq_pkg: shared types and constants of the price level order queue
// no dependencies
`default_nettype none
package plq_pkg;
   localparam int QueueDepthDefault = 64;
   localparam int SlotW  = 6;
   localparam int WordW  = 32;
   localparam int LvlVolW = 38;
   localparam int CountW = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_MATCH  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_DELETE  = 2'd1,
      KIND_TRADE   = 2'd2,
      KIND_NO_FILL = 2'd3
   } kind_type;

   localparam logic [0:0] CSR_LEVEL_PRICE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_LINK,
      ST_MREAD,
      ST_MEXEC
   } state_type;
endpackage
`default_nettype wire

FILE: hdl/plq_mem.sv
// plq_mem: slot memory holding id, volume and both links of each order
// depends on plq_pkg
`default_nettype none
module plq_mem #(
   parameter int QUEUE_DEPTH = plq_pkg::QueueDepthDefault
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [plq_pkg::SlotW-1:0]  wr_addr,
   input  wire logic [76:0]                wr_data,
   input  wire logic [plq_pkg::SlotW-1:0]  rd_addr,
   output logic      [76:0]                rd_data
);
   import plq_pkg::*;
   logic [76:0] mem [QUEUE_DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/price_level_order_queue_top.sv
// price_level_order_queue_top: control, level state and register port
// depends on plq_pkg and plq_mem
`default_nettype none
// Each order occupies one entry of a memory holding {id, volume, next, prev}
// with a registered read. Insert passes through read and exec, then link
// when the old tail's next link is patched; delete of the head or tail
// passes through read and exec, of a middle order also link (prev and next
// neighbors patched one after the other); match passes through mread and
// mexec per fill, or only mread when nothing fills; opcode 3 gives no result.
// busy is high from the accepting edge until the item is done. Every result
// is one cycle on rsp_valid and cannot be stalled.
module price_level_order_queue_top #(
   parameter int QUEUE_DEPTH = plq_pkg::QueueDepthDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [5:0]            req_slot,
   input  wire logic [31:0]           req_order_id,
   input  wire logic [31:0]           req_volume,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_error,
   output logic [31:0]                rsp_taker_id,
   output logic [31:0]                rsp_maker_id,
   output logic [5:0]                 rsp_maker_slot,
   output logic [31:0]                rsp_fill_volume,
   output logic [31:0]                rsp_trade_price,
   output logic [31:0]                rsp_taker_remaining,
   output logic                       rsp_removed_fulfilled,
   output logic [37:0]                rsp_level_volume,
   output logic [6:0]                 rsp_level_count,
   output logic                       rsp_last,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import plq_pkg::*;

   state_type state_ff, state_in;
   logic [31:0] price_ff;
   logic [QUEUE_DEPTH-1:0] used_ff, used_in;
   logic [SlotW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [6:0] count_ff, count_in;
   logic [37:0] total_ff, total_in;
   logic [1:0] op_ff;
   logic [5:0] slot_ff;
   logic [31:0] id_ff, vol_ff, vol_in;
   logic [1:0] step_ff, step_in;
   logic [SlotW-1:0] rnext_ff, rnext_in, rprev_ff, rprev_in;

   logic wr_en;
   logic [SlotW-1:0] wr_addr, rd_addr;
   logic [76:0] wr_data, rd_data;
   logic [SlotW-1:0] rd_next, rd_prev;
   logic [31:0] rd_id, rd_vol;

   plq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );
   assign rd_id   = rd_data[76:45];
   assign rd_vol  = rd_data[44:13];
   assign rd_next = rd_data[12:7];
   assign rd_prev = rd_data[6:1] ;

   logic slot_ok;
   logic [SlotW-1:0] s_a;
   assign s_a = slot_ff;
   assign slot_ok = ({26'd0, slot_ff} < QUEUE_DEPTH) && used_ff[s_a];
   logic ins_ok;
   assign ins_ok = ({26'd0, slot_ff} < QUEUE_DEPTH) && !used_ff[s_a];

   assign pready = 1'b1;
   assign prdata = price_ff;
   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) price_ff <= '0;
      else if (psel && penable && pwrite && paddr[2] == CSR_LEVEL_PRICE)
         price_ff <= pwdata;
   end

   logic [31:0] fill;
   assign fill = (rd_vol < vol_ff) ? rd_vol : vol_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = (req_opcode == OP_NONE) ? ST_IDLE :
                                         (req_opcode == OP_MATCH) ? ST_MREAD : ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (op_ff == OP_INSERT) state_in = (ins_ok && count_ff != 0) ? ST_LINK : ST_IDLE;
            else if (slot_ok && count_ff > 7'd1 && s_a != head_ff && s_a != tail_ff)
               state_in = ST_LINK;
            else state_in = ST_IDLE;
         end
         ST_LINK:  state_in = (op_ff == OP_DELETE && step_ff == 2'd0) ? ST_LINK : ST_IDLE;
         ST_MREAD: state_in = (count_ff == 0 || vol_ff == 0) ? ST_IDLE : ST_MEXEC;
         ST_MEXEC: state_in = (count_ff == 7'd1 && fill == rd_vol) || vol_ff == fill
                               ? ST_IDLE : ST_MREAD;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      used_in = used_ff; head_in = head_ff; tail_in = tail_ff;
      count_in = count_ff; total_in = total_ff; vol_in = vol_ff;
      step_in = step_ff;
      rnext_in = rnext_ff; rprev_in = rprev_ff;
      wr_en = 1'b0; wr_addr = s_a; wr_data = '0; rd_addr = s_a;
      rsp_valid = 1'b0; rsp_kind = KIND_INSERT; rsp_error = 1'b0;
      rsp_taker_id = '0; rsp_maker_id = '0; rsp_maker_slot = '0;
      rsp_fill_volume = '0; rsp_trade_price = '0; rsp_taker_remaining = '0;
      rsp_removed_fulfilled = 1'b0; rsp_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_READ: begin
            rd_addr = s_a;
            step_in = 2'd0;
         end
         ST_EXEC: begin
            rsp_valid = 1'b1; rsp_last = 1'b1; rsp_maker_slot = slot_ff;
            rnext_in = rd_next; rprev_in = rd_prev;
            if (op_ff == OP_INSERT) begin
               rsp_kind = KIND_INSERT; rsp_maker_id = id_ff; rsp_error = !ins_ok;
               if (ins_ok) begin
                  wr_en = 1'b1;
                  wr_data = {id_ff, vol_ff, s_a, tail_ff, 1'b0};
                  if (count_ff == 0) head_in = s_a;
                  rprev_in = tail_ff;
                  tail_in = s_a; used_in[s_a] = 1'b1;
                  count_in = count_ff + 7'd1;
                  total_in = total_ff + {6'd0, vol_ff};
                  rd_addr = tail_ff;
               end
            end else begin
               rsp_kind = KIND_DELETE; rsp_error = !slot_ok;
               if (slot_ok) begin
                  rsp_maker_id = rd_id;
                  rsp_removed_fulfilled = (rd_vol == 0);
                  if (count_ff <= 7'd1) begin
                     head_in = '0; tail_in = '0;
                  end else if (s_a == head_ff) head_in = rd_next;
                  else if (s_a == tail_ff) tail_in = rd_prev;
                  used_in[s_a] = 1'b0;
                  count_in = count_ff - 7'd1;
                  total_in = total_ff - {6'd0, rd_vol};
                  rd_addr = rd_prev;
               end
            end
         end
         ST_LINK: begin
            if (op_ff == OP_INSERT) begin
               wr_en = 1'b1; wr_addr = rprev_ff;
               wr_data = {rd_data[76:13], s_a, rd_data[6:0]};
            end else if (step_ff == 2'd0) begin
               wr_en = 1'b1; wr_addr = rprev_ff;
               wr_data = {rd_data[76:13], rnext_ff, rd_data[6:0]};
               rd_addr = rnext_ff; step_in = 2'd1;
            end else begin
               wr_en = 1'b1; wr_addr = rnext_ff;
               wr_data = {rd_data[76:7], rprev_ff, rd_data[0]};
            end
         end
         ST_MREAD: begin
            rd_addr = head_ff;
            if (count_ff == 0 || vol_ff == 0) begin
               rsp_valid = 1'b1; rsp_last = 1'b1; rsp_kind = KIND_NO_FILL;
               rsp_taker_id = id_ff; rsp_taker_remaining = vol_ff;
            end
         end
         ST_MEXEC: begin
            rsp_valid = 1'b1; rsp_kind = KIND_TRADE;
            rsp_taker_id = id_ff; rsp_maker_id = rd_id;
            rsp_maker_slot = head_ff;
            rsp_fill_volume = fill; rsp_trade_price = price_ff;
            rsp_taker_remaining = vol_ff - fill;
            vol_in = vol_ff - fill;
            total_in = total_ff - {6'd0, fill};
            wr_en = 1'b1; wr_addr = head_ff;
            wr_data = {rd_id, rd_vol - fill, rd_next, rd_prev, 1'b0};
            if (rd_vol == fill) begin
               used_in[head_ff] = 1'b0;
               count_in = count_ff - 7'd1;
               if (count_ff <= 7'd1) begin
                  head_in = '0; tail_in = '0;
               end else head_in = rd_next;
            end
            rsp_last = (state_in == ST_IDLE);
         end
         default: ;
      endcase
      rsp_level_volume = total_in; rsp_level_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; used_ff <= '0; head_ff <= '0; tail_ff <= '0;
         count_ff <= '0; total_ff <= '0; step_ff <= '0;
      end else begin
         state_ff <= state_in; used_ff <= used_in; head_ff <= head_in;
         tail_ff <= tail_in; count_ff <= count_in; total_ff <= total_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         op_ff <= req_opcode; slot_ff <= req_slot;
         id_ff <= req_order_id; vol_ff <= req_volume;
      end else vol_ff <= vol_in;
      rnext_ff <= rnext_in;
      rprev_ff <= rprev_in;
   end
endmodule
`default_nettype wire

FILE: hdl/plq_checker.sv
// plq_checker: port-level assertions for the price level order queue
// depends on price_level_order_queue_top
`default_nettype none
module plq_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic       rsp_last,
   input wire logic [1:0] rsp_kind,
   input wire logic       rsp_error,
   input wire logic [6:0] rsp_level_count
);
   import plq_pkg::*;
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level_count <= 7'd64) else $error("count over depth");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("result after last");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_kind == KIND_INSERT ||
      rsp_kind == KIND_DELETE)) else $error("bad error result");
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid) else $error("result while idle");
endmodule

bind price_level_order_queue_top plq_checker u_plq_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_last, .rsp_kind,
   .rsp_error, .rsp_level_count
);
`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for price_level_order_queue_top, predicts every result word
// depends on plq_pkg and the price_level_order_queue_top rtl
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import plq_pkg::*;

   typedef struct packed {
      opcode_type  op;
      logic [5:0]  slot;
      logic [31:0] id;
      logic [31:0] vol;
   } order_cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic        error;
      logic [31:0] taker_id;
      logic [31:0] maker_id;
      logic [5:0]  maker_slot;
      logic [31:0] fill;
      logic [31:0] price;
      logic [31:0] remaining;
      logic        fulfilled;
      logic [37:0] lvl_vol;
      logic [6:0]  lvl_cnt;
      logic        last;
   } book_word_type;

   logic clock, reset, start, busy;
   logic [1:0] req_opcode;
   logic [5:0] req_slot;
   logic [31:0] req_order_id, req_volume;
   logic rsp_valid, rsp_error, rsp_removed_fulfilled, rsp_last;
   logic [1:0] rsp_kind;
   logic [31:0] rsp_taker_id, rsp_maker_id, rsp_fill_volume, rsp_trade_price;
   logic [31:0] rsp_taker_remaining;
   logic [5:0] rsp_maker_slot;
   logic [37:0] rsp_level_volume;
   logic [6:0] rsp_level_count;
   logic psel, penable, pwrite, pready;
   logic [2:0] paddr;
   logic [31:0] pwdata, prdata;

   price_level_order_queue_top u_top (.*);

   // book model state
   logic [31:0] bk_price = 0;
   logic [31:0] bk_id [64];
   logic [31:0] bk_vol [64];
   logic [5:0]  bk_next [64];
   logic [5:0]  bk_prev [64];
   bit          bk_used [64];
   logic [5:0]  bk_head = 0, bk_tail = 0;
   int          bk_count = 0;
   logic [37:0] bk_total = 0;

   order_cmd_type pending_cmds[$];
   book_word_type expected_words[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0, gap_left = 0;
   bit stim_done = 0;

   function automatic book_word_type mk(kind_type k, logic e, logic [31:0] t,
                                        logic [31:0] m, logic [5:0] s, logic [31:0] f,
                                        logic [31:0] p, logic [31:0] r, logic ful);
      book_word_type w;
      w = '{k, e, t, m, s, f, p, r, ful, bk_total, bk_count[6:0], 1'b0};
      return w;
   endfunction

   task automatic unlink(input logic [5:0] s);
      if (bk_count <= 1) begin
         bk_head = 0;
         bk_tail = 0;
      end else if (s == bk_head) begin
         bk_head = bk_next[s];
      end else if (s == bk_tail) begin
         bk_tail = bk_prev[s];
      end else begin
         bk_next[bk_prev[s]] = bk_next[s];
         bk_prev[bk_next[s]] = bk_prev[s];
      end
      bk_used[s] = 0;
      if (bk_count > 0) bk_count--;
   endtask

   task automatic predict_book(input order_cmd_type c);
      book_word_type w [$];
      logic [31:0] rem, hv, fill, left;
      logic [5:0] h;
      if (c.op == OP_INSERT) begin
         if (!bk_used[c.slot]) begin
            bk_id[c.slot] = c.id;
            bk_vol[c.slot] = c.vol;
            if (bk_count == 0) begin
               bk_head = c.slot;
            end else begin
               bk_next[bk_tail] = c.slot;
               bk_prev[c.slot] = bk_tail;
            end
            bk_tail = c.slot;
            bk_used[c.slot] = 1;
            bk_count++;
            bk_total = bk_total + c.vol;
            w.push_back(mk(KIND_INSERT, 0, 0, c.id, c.slot, 0, 0, 0, 0));
         end else begin
            w.push_back(mk(KIND_INSERT, 1, 0, c.id, c.slot, 0, 0, 0, 0));
         end
      end else if (c.op == OP_DELETE) begin
         if (!bk_used[c.slot]) begin
            w.push_back(mk(KIND_DELETE, 1, 0, 0, c.slot, 0, 0, 0, 0));
         end else begin
            left = bk_vol[c.slot];
            unlink(c.slot);
            bk_total = bk_total - left;
            w.push_back(mk(KIND_DELETE, 0, 0, bk_id[c.slot], c.slot, 0, 0, 0, left == 0));
         end
      end else if (c.op == OP_MATCH) begin
         rem = c.vol;
         if (bk_count == 0 || rem == 0) begin
            w.push_back(mk(KIND_NO_FILL, 0, c.id, 0, 0, 0, 0, rem, 0));
         end else begin
            while (bk_count > 0 && rem > 0 && w.size() < 64) begin
               h = bk_head;
               hv = bk_vol[h];
               fill = hv < rem ? hv : rem;
               bk_vol[h] = hv - fill;
               rem -= fill;
               bk_total = bk_total - fill;
               if (bk_vol[h] == 0) unlink(h);
               w.push_back(mk(KIND_TRADE, 0, c.id, bk_id[h], h, fill, bk_price, rem, 0));
            end
         end
      end
      if (w.size() > 0) w[w.size()-1].last = 1;
      foreach (w[i]) expected_words.push_back(w[i]);
   endtask

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_opcode <= OP_NONE;
         req_slot <= 0;
         req_order_id <= 0;
         req_volume <= 0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (start && !busy) begin
         predict_book(pending_cmds.pop_front());
         start <= 0;
         if (burst_left > 0) burst_left <= burst_left - 1;
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() > 0 && !busy) begin
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 8);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               start <= 1;
               req_opcode <= pending_cmds[0].op;
               req_slot <= pending_cmds[0].slot;
               req_order_id <= pending_cmds[0].id;
               req_volume <= pending_cmds[0].vol;
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      book_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_kind, 0);
         end else begin
            e = expected_words.pop_front();
            if (rsp_kind != e.kind) report_mismatch("kind", rsp_kind, e.kind);
            if (rsp_error != e.error) report_mismatch("error", rsp_error, e.error);
            if (rsp_taker_id != e.taker_id)
               report_mismatch("taker_id", rsp_taker_id, e.taker_id);
            if (rsp_maker_id != e.maker_id)
               report_mismatch("maker_id", rsp_maker_id, e.maker_id);
            if (rsp_maker_slot != e.maker_slot)
               report_mismatch("maker_slot", rsp_maker_slot, e.maker_slot);
            if (rsp_fill_volume != e.fill) report_mismatch("fill", rsp_fill_volume, e.fill);
            if (rsp_trade_price != e.price) report_mismatch("price", rsp_trade_price, e.price);
            if (rsp_taker_remaining != e.remaining)
               report_mismatch("remaining", rsp_taker_remaining, e.remaining);
            if (rsp_removed_fulfilled != e.fulfilled)
               report_mismatch("fulfilled", rsp_removed_fulfilled, e.fulfilled);
            if (rsp_level_volume != e.lvl_vol)
               report_mismatch("level_volume", rsp_level_volume, e.lvl_vol);
            if (rsp_level_count != e.lvl_cnt)
               report_mismatch("level_count", rsp_level_count, e.lvl_cnt);
            if (rsp_last != e.last) report_mismatch("last", rsp_last, e.last);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("price_level_order_queue_top regression: fail");
         $finish;
      end
   end

   task automatic csr_write(input logic [31:0] value);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {CSR_LEVEL_PRICE, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      bk_price = value;
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || start || expected_words.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic order_cmd_type cmd(opcode_type o, logic [5:0] s, logic [31:0] i,
                                         logic [31:0] v);
      order_cmd_type c;
      c = '{o, s, i, v};
      return c;
   endfunction

   // slot the generator believes occupied, tracked ahead of issue
   bit gen_used [64];

   task automatic add(input order_cmd_type c);
      if (c.op == OP_INSERT) gen_used[c.slot] = 1;
      if (c.op == OP_DELETE) gen_used[c.slot] = 0;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [31:0] rand_vol();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hffff_ffff;
         2: return $urandom;
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   function automatic logic [5:0] pick_slot(bit want_used);
      int n;
      n = 0;
      foreach (gen_used[i]) if (gen_used[i] == want_used) n++;
      if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      n = $urandom_range(1, n);
      foreach (gen_used[i]) if (gen_used[i] == want_used && --n == 0) return 6'(i);
      return 0;
   endfunction

   task automatic run_random(input int count);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 19);
         if (r < 9) add(cmd(OP_INSERT, pick_slot(0), $urandom, rand_vol()));
         else if (r < 13) add(cmd(OP_DELETE, pick_slot(1), 0, 0));
         else if (r < 19) add(cmd(OP_MATCH, 6'($urandom), $urandom,
                                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 90)));
         else pending_cmds.push_back(cmd(OP_NONE, 6'($urandom), $urandom, $urandom));
      end
      wait_drained();
   endtask

   initial begin
      reset = 1;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      csr_write(32'hffff_ffff);
      // directed
      add(cmd(OP_MATCH, 0, 32'h1111, 5));
      add(cmd(OP_DELETE, 5, 0, 0));
      add(cmd(OP_INSERT, 0, 32'hffff_ffff, 32'hffff_ffff));
      add(cmd(OP_INSERT, 0, 1, 1));
      add(cmd(OP_INSERT, 63, 0, 0));
      add(cmd(OP_INSERT, 7, 32'h5a5a, 10));
      add(cmd(OP_INSERT, 9, 32'ha5a5, 3));
      add(cmd(OP_MATCH, 0, 32'h2222, 0));
      pending_cmds.push_back(cmd(OP_NONE, 63, 32'hffff_ffff, 32'hffff_ffff));
      add(cmd(OP_DELETE, 7, 0, 0));
      add(cmd(OP_DELETE, 63, 0, 0));
      add(cmd(OP_MATCH, 0, 32'h3333, 32'hffff_fffe));
      add(cmd(OP_INSERT, 1, 5, 4));
      add(cmd(OP_MATCH, 63, 32'hffff_ffff, 32'hffff_ffff));
      add(cmd(OP_DELETE, 1, 0, 0));
      wait_drained();
      csr_write(0);
      run_random(50);
      csr_write($urandom);
      // fill every slot the generator believes free for a long fill sequence
      for (int i = 0; i < 64; i++)
         if (!gen_used[i]) add(cmd(OP_INSERT, 6'(i), $urandom, $urandom_range(0, 3)));
      add(cmd(OP_MATCH, 0, 32'h4444, 32'hffff_ffff));
      wait_drained();
      csr_write(32'h8000_0001);
      run_random(90);
      if (errors == 0)
         $display("price_level_order_queue_top regression: pass");
      else
         $display("price_level_order_queue_top regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
hdl/plq_pkg.sv
hdl/plq_mem.sv
hdl/price_level_order_queue_top.sv
hdl/plq_checker.sv
tb/tb.sv
